/* hw/rtl/rmis_pkg.sv */
package rmis_pkg;

  // Size of the architectural register file.
  localparam int unsigned NumRegs = 6;
  localparam int unsigned RegIdxW = (NumRegs > 1) ? $clog2(NumRegs) : 1;

  // Configuration register indexes.
  localparam logic [1:0] CfgPtrReg  = 2'd0;
  localparam logic [1:0] CfgStart   = 2'd1;
  localparam logic [1:0] CfgProgLen = 2'd2;

  typedef enum logic [3:0] {
    OpAddr = 4'd0,
    OpAddi = 4'd1,
    OpMulr = 4'd2,
    OpMuli = 4'd3,
    OpBanr = 4'd4,
    OpBani = 4'd5,
    OpBorr = 4'd6,
    OpBori = 4'd7,
    OpSetr = 4'd8,
    OpSeti = 4'd9,
    OpGtir = 4'd10,
    OpGtri = 4'd11,
    OpGtrr = 4'd12,
    OpEqir = 4'd13,
    OpEqri = 4'd14,
    OpEqrr = 4'd15
  } op_e;

  // True when the first operand names a register.
  function automatic logic a_is_reg(op_e op);
    return !(op == OpSeti || op == OpGtir || op == OpEqir);
  endfunction

  // True when the second operand names a register.
  function automatic logic b_is_reg(op_e op);
    logic res;
    case (op)
      OpAddr, OpMulr, OpBanr, OpBorr, OpGtir, OpGtrr, OpEqir, OpEqrr: res = 1'b1;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

/* hw/rtl/rmis_mul.sv */
// 64-bit wrapping multiply built from one 32x32 multiplier, used in turn for the low product and the two cross terms.
// The operands must hold steady from start until the product is consumed.
module rmis_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        consume_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StHiA  = 2'd1;
  localparam logic [1:0] StHiB  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;

  always_comb begin
    case (state_q)
      StHiA: begin
        mul_x = a_i[63:32];
        mul_y = b_i[31:0];
      end
      StHiB: begin
        mul_x = a_i[31:0];
        mul_y = b_i[63:32];
      end
      default: begin
        mul_x = a_i[31:0];
        mul_y = b_i[31:0];
      end
    endcase
  end

  assign mul_p = 64'(mul_x) * 64'(mul_y);

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          acc_d   = mul_p;
          state_d = StHiA;
        end
      end
      StHiA: begin
        // Cross terms only reach the upper word.
        acc_d   = {acc_q[63:32] + mul_p[31:0], acc_q[31:0]};
        state_d = StHiB;
      end
      StHiB: begin
        acc_d   = {acc_q[63:32] + mul_p[31:0], acc_q[31:0]};
        state_d = StDone;
      end
      StDone: begin
        if (consume_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign done_o = (state_q == StDone);
  assign prod_o = acc_q;

endmodule

/* hw/rtl/register_machine_instruction_step_unit.sv */
// Instruction step unit for a six-register, sixteen-opcode machine. Each input beat is one
// instruction (opcode, two operands, destination) and produces exactly one output beat with
// the next instruction pointer, a halted flag, the register written and its value, and a
// bad-index flag. An accepted beat lands in an input register; the execute logic then reads
// the architectural registers, applies restart and the instruction-pointer binding, runs the
// ALU and commits the register file, the pointer and the output register in a single edge.
// Throughput is one instruction per cycle while the output can drain, for every opcode but
// the two multiplies: those hold the execute stage until the 64-bit wrapping product is
// formed by one shared 32x32 multiplier over three passes. While a finished result waits on
// the output side, the input register still takes one more beat; after that in_ready_o stays
// low until the result beat is accepted, and with both registers full in_ready_o follows
// out_ready_i in the same cycle, for a multiply once its product is done. Configuration
// (pointer register, start value, program length) is written through the plain write port,
// by the user only while idle (not enforced); writes to an index beyond the list are ignored.
module register_machine_instruction_step_unit
  import rmis_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  // Instruction input channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               restart_i,
  input  logic [3:0]         mode_i,
  input  logic [31:0]        operand_a_i,
  input  logic [31:0]        operand_b_i,
  input  logic [2:0]         dest_sel_i,
  // Result output channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        next_pointer_o,
  output logic               halted_o,
  output logic [2:0]         written_index_o,
  output logic signed [63:0] written_value_o,
  output logic               bad_index_o
);

  // Configuration registers.
  logic [2:0]  ptr_reg_q;
  logic        start_val_q;
  logic [15:0] prog_len_q;

  // Architectural state.
  logic [63:0] rf_q [NumRegs];
  logic [31:0] pointer_q;

  // Input register.
  logic        in_valid_q;
  logic        restart_q;
  op_e         mode_q;
  logic [31:0] opa_q;
  logic [31:0] opb_q;
  logic [2:0]  dest_q;

  // Output register.
  logic        out_valid_q;
  logic [31:0] out_ptr_q;
  logic        out_halt_q;
  logic [2:0]  out_idx_q;
  logic [63:0] out_val_q;
  logic        out_bad_q;

  // Execute stage signals.
  logic               bound;
  logic [RegIdxW-1:0] ptr_idx;
  logic [31:0]        ptr_base;
  logic [63:0]        rf_eff  [NumRegs];
  logic [63:0]        rf_next [NumRegs];
  logic               a_reg, b_reg, a_ok, b_ok, dest_ok, bad;
  logic [63:0]        va, vb, res;
  logic [31:0]        next_ptr;
  logic               next_halt;
  logic               is_mul;
  logic               mul_done;
  logic [63:0]        mul_prod;
  logic               exec_fire;

  assign is_mul    = (mode_q == OpMulr) || (mode_q == OpMuli);
  assign exec_fire = in_valid_q && (!out_valid_q || out_ready_i) && (!is_mul || mul_done);
  assign in_ready_o = !in_valid_q || exec_fire;

  // The bound register sees the pointer before the instruction reads its operands.
  // Restart resets the registers (register 0 to the start value) and the pointer ahead of that.
  assign bound    = 32'(ptr_reg_q) < NumRegs;
  assign ptr_idx  = RegIdxW'(ptr_reg_q);
  assign ptr_base = restart_q ? 32'd0 : pointer_q;

  always_comb begin
    for (int i = 0; i < NumRegs; i++) begin
      if (restart_q) begin
        rf_eff[i] = (i == 0) ? {63'd0, start_val_q} : 64'd0;
      end else begin
        rf_eff[i] = rf_q[i];
      end
      if (bound && (ptr_idx == RegIdxW'(i))) begin
        rf_eff[i] = {32'd0, ptr_base};
      end
    end
  end

  // Operand fetch and index checks. An immediate operand is never checked.
  assign a_reg   = a_is_reg(mode_q);
  assign b_reg   = b_is_reg(mode_q);
  assign a_ok    = opa_q < NumRegs;
  assign b_ok    = opb_q < NumRegs;
  assign dest_ok = 32'(dest_q) < NumRegs;
  assign bad     = (a_reg && !a_ok) || (b_reg && !b_ok) || !dest_ok;

  assign va = (a_reg && a_ok) ? rf_eff[RegIdxW'(opa_q)] : {32'd0, opa_q};
  assign vb = (b_reg && b_ok) ? rf_eff[RegIdxW'(opb_q)] : {32'd0, opb_q};

  rmis_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_valid_q && is_mul),
    .consume_i (exec_fire && is_mul),
    .a_i       (va),
    .b_i       (vb),
    .done_o    (mul_done),
    .prod_o    (mul_prod)
  );

  always_comb begin
    case (mode_q)
      OpAddr, OpAddi:         res = va + vb;
      OpMulr, OpMuli:         res = mul_prod;
      OpBanr, OpBani:         res = va & vb;
      OpBorr, OpBori:         res = va | vb;
      OpSetr, OpSeti:         res = va;
      OpGtir, OpGtri, OpGtrr: res = {63'd0, $signed(va) > $signed(vb)};
      default:                res = {63'd0, va == vb};
    endcase
  end

  // Register file after the write, and the pointer for the next fetch.
  always_comb begin
    for (int i = 0; i < NumRegs; i++) begin
      rf_next[i] = rf_eff[i];
    end
    if (!bad) begin
      rf_next[RegIdxW'(dest_q)] = res;
    end
  end

  assign next_ptr  = bound ? (rf_next[ptr_idx][31:0] + 32'd1) : (ptr_base + 32'd1);
  assign next_halt = next_ptr >= {16'd0, prog_len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_reg_q   <= '0;
      start_val_q <= 1'b0;
      prog_len_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgPtrReg:  ptr_reg_q   <= cfg_wdata_i[2:0];
        CfgStart:   start_val_q <= cfg_wdata_i[0];
        CfgProgLen: prog_len_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        rf_q[i] <= '0;
      end
      pointer_q <= '0;
    end else if (exec_fire) begin
      for (int i = 0; i < NumRegs; i++) begin
        rf_q[i] <= rf_next[i];
      end
      pointer_q <= next_ptr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      restart_q <= restart_i;
      mode_q    <= op_e'(mode_i);
      opa_q     <= operand_a_i;
      opb_q     <= operand_b_i;
      dest_q    <= dest_sel_i;
    end
    if (exec_fire) begin
      out_ptr_q  <= next_ptr;
      out_halt_q <= next_halt;
      out_idx_q  <= bad ? 3'd0 : dest_q;
      out_val_q  <= bad ? 64'd0 : res;
      out_bad_q  <= bad;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign next_pointer_o  = out_ptr_q;
  assign halted_o        = out_halt_q;
  assign written_index_o = out_idx_q;
  assign written_value_o = $signed(out_val_q);
  assign bad_index_o     = out_bad_q;

endmodule
